[hw/rtl/sbl_pkg.sv]
// Shared types, constants and character-class functions for the source byte lexer.
package sbl_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_NUM     = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_SLASH   = 3'd3,
        MODE_EQ      = 3'd4,
        MODE_COMMENT = 3'd5
    } mode_t;

    typedef logic [4:0] kind_t;

    localparam kind_t KIND_NUMBER = 5'd0;
    localparam kind_t KIND_IDENT  = 5'd1;
    localparam kind_t KIND_PRINT  = 5'd2;
    localparam kind_t KIND_PLUS   = 5'd9;
    localparam kind_t KIND_MINUS  = 5'd10;
    localparam kind_t KIND_STAR   = 5'd11;
    localparam kind_t KIND_SLASH  = 5'd12;
    localparam kind_t KIND_LPAREN = 5'd13;
    localparam kind_t KIND_RPAREN = 5'd14;
    localparam kind_t KIND_SEMI   = 5'd15;
    localparam kind_t KIND_LBRACE = 5'd16;
    localparam kind_t KIND_RBRACE = 5'd17;
    localparam kind_t KIND_ASSIGN = 5'd18;
    localparam kind_t KIND_EQEQ   = 5'd19;
    localparam kind_t KIND_LESS   = 5'd20;
    localparam kind_t KIND_GREATER = 5'd21;
    localparam kind_t KIND_END    = 5'd22;

    // ASCII codes the lexer keys on
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LESS    = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GREATER = 8'h3E;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_UNDER   = 8'h5F;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    localparam int NUM_KW = 7;

    // keyword text, first character in the low byte, zero padded
    localparam logic [39:0] KW_TEXT [NUM_KW] = '{
        40'h74_6E_69_72_70,   // print
        40'h00_00_74_65_6C,   // let
        40'h00_00_00_66_69,   // if
        40'h00_65_73_6C_65,   // else
        40'h65_6C_69_68_77,   // while
        40'h00_65_75_72_74,   // true
        40'h65_73_6C_61_66    // false
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd5, 3'd3, 3'd2, 3'd4, 3'd5, 3'd4, 3'd5
    };

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
               ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z));
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    // single-character operator kind, KIND_NUMBER when not an operator
    function automatic kind_t op_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_NUMBER;
        unique case (c)
            CH_PLUS:    k = KIND_PLUS;
            CH_MINUS:   k = KIND_MINUS;
            CH_STAR:    k = KIND_STAR;
            CH_LPAREN:  k = KIND_LPAREN;
            CH_RPAREN:  k = KIND_RPAREN;
            CH_SEMI:    k = KIND_SEMI;
            CH_LBRACE:  k = KIND_LBRACE;
            CH_RBRACE:  k = KIND_RBRACE;
            CH_LESS:    k = KIND_LESS;
            CH_GREATER: k = KIND_GREATER;
            default:    k = KIND_NUMBER;
        endcase
        return k;
    endfunction

    // len3: identifier length, 7 when longer than five
    function automatic kind_t ident_kind(input logic [39:0] prefix, input logic [2:0] len3);
        kind_t k;
        k = KIND_IDENT;
        for (int i = NUM_KW - 1; i >= 0; i--)
        begin
            if ((len3 == KW_LEN[i]) && (prefix == KW_TEXT[i]))
            begin
                k = KIND_PRINT + kind_t'(i);
            end
        end
        return k;
    endfunction

endpackage

[hw/rtl/sbl_byte_if.sv]
// Byte input channel: valid/ready handshake with source byte and final flag.
interface sbl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;
    logic       final_byte;

    modport source (output valid, output source_byte, output final_byte, input ready);
    modport sink   (input valid, input source_byte, input final_byte, output ready);
endinterface

[hw/rtl/sbl_token_if.sv]
// Token output channel: valid/ready handshake with token fields.
interface sbl_token_if #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
);
    logic                   valid;
    logic                   ready;
    logic [4:0]             token_kind;
    logic [LINE_BITS-1:0]   token_line;
    logic [OFFSET_BITS-1:0] token_start;
    logic [LENGTH_BITS-1:0] token_length;
    logic                   run_last;

    modport source (output valid, output token_kind, output token_line, output token_start,
                    output token_length, output run_last, input ready);
    modport sink   (input valid, input token_kind, input token_line, input token_start,
                    input token_length, input run_last, output ready);
endinterface

[hw/rtl/source_byte_lexer_core.sv]
// Streaming source lexer: one byte per beat in, tokens out through a small result queue.
//
//   channel  dir  beat payload
//   -------  ---  ------------------------------------------------------------
//   src      in   source_byte[7:0], final_byte
//   tok      out  token_kind[4:0], token_line, token_start, token_length, run_last
//
// One byte is accepted per cycle while src.ready is high. The scan state updates in the
// accepting cycle and the 0..3 tokens it causes are written at once into a 4-entry result
// queue; tok drains one token per cycle while tok.ready is high. src.ready is high while
// the queue holds at most one token, which keeps room for the worst-case three pushes
// and lets a token-per-byte stream run at full rate. A stall on tok backs up into
// src.ready only.
// Reset (rst_n low, async) clears the scan state and empties the queue; a final
// byte returns the scan state to its reset values for the next source.
module source_byte_lexer_core #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    sbl_byte_if.sink     src,
    sbl_token_if.source  tok
);

    localparam int QDEPTH = 4;
    localparam int QPTR   = $clog2(QDEPTH);

    typedef struct packed {
        sbl_pkg::kind_t         kind;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] start;
        logic [LENGTH_BITS-1:0] length;
        logic                   last;
    } tok_t;

    // scan state
    sbl_pkg::mode_t         mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [OFFSET_BITS-1:0] pstart_reg, pstart_next;
    logic [LENGTH_BITS-1:0] plen_reg, plen_next;
    logic [39:0]            prefix_reg, prefix_next;

    // result queue
    tok_t                   q_reg [QDEPTH];
    tok_t                   q_next [QDEPTH];
    logic [QPTR-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [QPTR-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [QPTR:0]          count_reg, count_next;

    logic                   accept;
    logic                   pop;
    logic [7:0]             c;
    logic                   fin;
    logic                   used;
    logic                   t0_v, t1_v, tf_v;
    tok_t                   t0, t1, tf, te;
    tok_t                   slot [QDEPTH];
    logic [QPTR:0]          n_push;

    assign c      = src.source_byte;
    assign fin    = src.final_byte;
    assign accept = src.valid && src.ready;
    assign pop    = tok.valid && tok.ready;

    // room for a worst-case burst of three tokens
    assign src.ready = (count_reg <= (QPTR+1)'(1));

    // identifier length folded to 3 bits for keyword matching
    function automatic logic [2:0] short_len(input logic [LENGTH_BITS-1:0] len);
        return (len < LENGTH_BITS'(6)) ? len[2:0] : 3'd7;
    endfunction

    // ---------------------------------------------------------------------
    // scan step for the byte at the input
    // ---------------------------------------------------------------------
    always_comb
    begin
        used        = 1'b0;
        t0_v        = 1'b0;
        t1_v        = 1'b0;
        mode_next   = mode_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        prefix_next = prefix_reg;

        t0.kind   = sbl_pkg::KIND_NUMBER;
        t0.line   = line_reg;
        t0.start  = pstart_reg;
        t0.length = plen_reg;
        t0.last   = !t1_v && !fin;

        // pending token either continues or is flushed
        unique case (mode_reg)
            sbl_pkg::MODE_NUM:
            begin
                if (sbl_pkg::is_digit(c))
                begin
                    plen_next = (plen_reg == '1) ? plen_reg : plen_reg + 1'b1;
                    used      = 1'b1;
                end
                else
                begin
                    t0_v      = 1'b1;
                    mode_next = sbl_pkg::MODE_IDLE;
                end
            end
            sbl_pkg::MODE_IDENT:
            begin
                if (sbl_pkg::is_word(c))
                begin
                    for (int j = 0; j < 5; j++)
                    begin
                        if (plen_reg == LENGTH_BITS'(j))
                        begin
                            prefix_next[8*j +: 8] = c;
                        end
                    end
                    plen_next = (plen_reg == '1) ? plen_reg : plen_reg + 1'b1;
                    used      = 1'b1;
                end
                else
                begin
                    t0_v      = 1'b1;
                    t0.kind   = sbl_pkg::ident_kind(prefix_reg, short_len(plen_reg));
                    mode_next = sbl_pkg::MODE_IDLE;
                end
            end
            sbl_pkg::MODE_SLASH:
            begin
                if (c == sbl_pkg::CH_SLASH)
                begin
                    mode_next = sbl_pkg::MODE_COMMENT;
                    used      = 1'b1;
                end
                else
                begin
                    t0_v      = 1'b1;
                    t0.kind   = sbl_pkg::KIND_SLASH;
                    t0.length = LENGTH_BITS'(1);
                    mode_next = sbl_pkg::MODE_IDLE;
                end
            end
            sbl_pkg::MODE_EQ:
            begin
                t0_v      = 1'b1;
                mode_next = sbl_pkg::MODE_IDLE;
                if (c == sbl_pkg::CH_EQ)
                begin
                    t0.kind   = sbl_pkg::KIND_EQEQ;
                    t0.length = LENGTH_BITS'(2);
                    used      = 1'b1;
                end
                else
                begin
                    t0.kind   = sbl_pkg::KIND_ASSIGN;
                    t0.length = LENGTH_BITS'(1);
                end
            end
            sbl_pkg::MODE_COMMENT:
            begin
                used = 1'b1;
                if (c == sbl_pkg::CH_NL)
                begin
                    mode_next = sbl_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                mode_next = sbl_pkg::MODE_IDLE;
            end
        endcase

        // byte not taken by the pending token starts something new
        t1.kind   = sbl_pkg::op_kind(c);
        t1.line   = line_reg;
        t1.start  = pos_reg;
        t1.length = LENGTH_BITS'(1);
        t1.last   = !fin;

        if (!used)
        begin
            priority if (sbl_pkg::is_blank(c))
            begin
                mode_next = sbl_pkg::MODE_IDLE;
            end
            else if (sbl_pkg::is_digit(c))
            begin
                mode_next   = sbl_pkg::MODE_NUM;
                pstart_next = pos_reg;
                plen_next   = LENGTH_BITS'(1);
            end
            else if (sbl_pkg::is_alpha(c) || (c == sbl_pkg::CH_UNDER))
            begin
                mode_next   = sbl_pkg::MODE_IDENT;
                pstart_next = pos_reg;
                plen_next   = LENGTH_BITS'(1);
                prefix_next = {32'b0, c};
            end
            else if (c == sbl_pkg::CH_SLASH)
            begin
                mode_next   = sbl_pkg::MODE_SLASH;
                pstart_next = pos_reg;
                plen_next   = LENGTH_BITS'(1);
            end
            else if (c == sbl_pkg::CH_EQ)
            begin
                mode_next   = sbl_pkg::MODE_EQ;
                pstart_next = pos_reg;
                plen_next   = LENGTH_BITS'(1);
            end
            else
            begin
                t1_v = (t1.kind != sbl_pkg::KIND_NUMBER);
            end
        end

        // t0 is last only if nothing follows it
        t0.last = !t1_v && !fin;

        // every newline counts, inside a comment or not
        line_next = ((c == sbl_pkg::CH_NL) && (line_reg != '1)) ? line_reg + 1'b1 : line_reg;
        pos_next  = (pos_reg == '1) ? pos_reg : pos_reg + 1'b1;

        // end of source: flush what is pending after this byte, then the end token
        tf.line   = line_next;
        tf.start  = pstart_next;
        tf.length = plen_next;
        tf.last   = 1'b0;
        tf.kind   = sbl_pkg::KIND_NUMBER;
        tf_v      = 1'b0;
        unique case (mode_next)
            sbl_pkg::MODE_NUM:
            begin
                tf_v = fin;
            end
            sbl_pkg::MODE_IDENT:
            begin
                tf_v    = fin;
                tf.kind = sbl_pkg::ident_kind(prefix_next, short_len(plen_next));
            end
            sbl_pkg::MODE_SLASH:
            begin
                tf_v      = fin;
                tf.kind   = sbl_pkg::KIND_SLASH;
                tf.length = LENGTH_BITS'(1);
            end
            sbl_pkg::MODE_EQ:
            begin
                tf_v      = fin;
                tf.kind   = sbl_pkg::KIND_ASSIGN;
                tf.length = LENGTH_BITS'(1);
            end
            default:
            begin
                tf_v = 1'b0;
            end
        endcase

        te.kind   = sbl_pkg::KIND_END;
        te.line   = line_next;
        te.start  = pos_next;
        te.length = '0;
        te.last   = 1'b1;
    end

    // pack the valid tokens of this byte into consecutive slots
    always_comb
    begin
        logic [QPTR-1:0] n;
        n = '0;
        for (int i = 0; i < QDEPTH; i++)
        begin
            slot[i] = te;
        end
        if (t0_v)
        begin
            slot[n] = t0;
            n       = n + 1'b1;
        end
        if (t1_v)
        begin
            slot[n] = t1;
            n       = n + 1'b1;
        end
        if (tf_v)
        begin
            slot[n] = tf;
            n       = n + 1'b1;
        end
        slot[n] = te;
        n_push = (QPTR+1)'(t0_v) + (QPTR+1)'(t1_v) + (QPTR+1)'(tf_v) + (QPTR+1)'(fin);
    end

    // queue write and pointer bookkeeping
    always_comb
    begin
        logic [QPTR-1:0] off;
        for (int i = 0; i < QDEPTH; i++)
        begin
            off       = QPTR'(i) - wr_ptr_reg;
            q_next[i] = q_reg[i];
            if (accept && ({1'b0, off} < n_push))
            begin
                q_next[i] = slot[off];
            end
        end
        wr_ptr_next = accept ? wr_ptr_reg + n_push[QPTR-1:0] : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (accept ? n_push : '0) - (QPTR+1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < QDEPTH; i++)
        begin
            q_reg[i] <= q_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            mode_reg   <= sbl_pkg::MODE_IDLE;
            line_reg   <= LINE_BITS'(1);
            pos_reg    <= '0;
            pstart_reg <= '0;
            plen_reg   <= '0;
            prefix_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (accept)
            begin
                if (fin)
                begin
                    mode_reg   <= sbl_pkg::MODE_IDLE;
                    line_reg   <= LINE_BITS'(1);
                    pos_reg    <= '0;
                    pstart_reg <= '0;
                    plen_reg   <= '0;
                    prefix_reg <= '0;
                end
                else
                begin
                    mode_reg   <= mode_next;
                    line_reg   <= line_next;
                    pos_reg    <= pos_next;
                    pstart_reg <= pstart_next;
                    plen_reg   <= plen_next;
                    prefix_reg <= prefix_next;
                end
            end
        end
    end

    assign tok.valid        = (count_reg != '0);
    assign tok.token_kind   = q_reg[rd_ptr_reg].kind;
    assign tok.token_line   = q_reg[rd_ptr_reg].line;
    assign tok.token_start  = q_reg[rd_ptr_reg].start;
    assign tok.token_length = q_reg[rd_ptr_reg].length;
    assign tok.run_last     = q_reg[rd_ptr_reg].last;

endmodule
